FILE: src/software_timer_table_unit_assert.svh
// Assertion macros for the software timer table unit.
`ifndef SOFTWARE_TIMER_TABLE_UNIT_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define STTU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked property, live through reset too
`define STTU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STTU_ASSERT(lbl, prop, msg)
`define STTU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/sttu_pkg.sv
// Package: types, sizes and codes of the software timer table unit.
package sttu_pkg;
	localparam int TIMER_SLOTS = 16;
	localparam int DELAY_BITS  = 32;
	localparam int SLOT_W      = $clog2(TIMER_SLOTS);
	localparam int CMP_W       = (SLOT_W > 4) ? SLOT_W : 4;
	localparam int TAG_W       = 16;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_MODIFY = 2'd2;
	localparam logic [1:0] KIND_TICK   = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_NOT_LIVE = 2'd2;

	localparam logic RKIND_ACK  = 1'b0;
	localparam logic RKIND_FIRE = 1'b1;

	typedef struct packed {
		logic                  live;
		logic [DELAY_BITS-1:0] delay;
		logic                  hdl;
		logic [TAG_W-1:0]      tag;
	} slot_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [3:0]            handle;
		logic [DELAY_BITS-1:0] delay;
		logic                  hdl;
		logic [TAG_W-1:0]      tag;
	} cmd_t;

	typedef struct packed {
		logic fire;  // slot expired and has a handler
		logic hit;   // delete or modify applied
		logic took;  // add claimed this slot
	} evt_t;
endpackage

FILE: src/sttu_cell.sv
// One timer slot cell of the rotating ring.
module sttu_cell import sttu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  slot_t d,
	output slot_t q
);
	logic                  live_q;
	logic [DELAY_BITS-1:0] delay_q;
	logic                  hdl_q;
	logic [TAG_W-1:0]      tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (shift) begin
			live_q <= d.live;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			delay_q <= d.delay;
			hdl_q   <= d.hdl;
			tag_q   <= d.tag;
		end
	end

	assign q = '{live: live_q, delay: delay_q, hdl: hdl_q, tag: tag_q};
endmodule

FILE: src/sttu_proc.sv
// Update logic applied to the slot leaving the head of the ring.
module sttu_proc import sttu_pkg::*; (
	input  cmd_t              cmd,
	input  logic [SLOT_W-1:0] idx,
	input  logic              add_done,
	input  slot_t             cur,
	output slot_t             nxt,
	output evt_t              evt
);
	logic [DELAY_BITS-1:0] dec;
	logic                  addressed;

	assign dec       = cur.delay - DELAY_BITS'(1);
	assign addressed = (CMP_W'(idx) == CMP_W'(cmd.handle)) && cur.live && (cur.delay != '0);

	always_comb begin
		nxt = cur;
		evt = '0;
		case (cmd.kind)
			KIND_ADD: begin
				if (!add_done && !cur.live) begin
					nxt      = '{live: 1'b1, delay: cmd.delay, hdl: cmd.hdl, tag: cmd.tag};
					evt.took = 1'b1;
				end
			end
			KIND_DELETE: begin
				if (addressed) begin
					nxt.live = 1'b0;
					evt.hit  = 1'b1;
				end
			end
			KIND_MODIFY: begin
				if (addressed) begin
					nxt.delay = cmd.delay;
					evt.hit   = 1'b1;
				end
			end
			KIND_TICK: begin
				if (cur.live) begin
					nxt.delay = dec;
					if (dec == '0) begin
						nxt.live = 1'b0;
						evt.fire = cur.hdl;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end
endmodule

FILE: src/software_timer_table_unit.sv
// Top level: software timer table, a ring of slot cells with a pass sequencer.
//
// A command runs from its start transfer to the next possible start as
// follows. The start edge latches the command and the pass begins at once.
// Then come one full rotation of the slot ring (one slot through the update
// logic per cycle), the acknowledgement build state, and the acknowledgement
// on the ports with busy already low. busy is high for the whole pass and
// the acknowledgement build state. Results are shown for exactly one cycle
// with result_strobe high and cannot be held off: a tick gives one fire
// result per expiring slot that has a handler, in slot order, and every
// command ends with one acknowledgement (last = 1). The acknowledgement may
// still be on the ports in the cycle a new start is taken.
`include "software_timer_table_unit_assert.svh"
module software_timer_table_unit import sttu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [3:0]            handle,
	input  logic [31:0]           delay_ticks,
	input  logic                  handler_valid,
	input  logic [15:0]           handler_tag,
	output logic                  result_strobe,
	output logic                  result_kind,
	output logic [1:0]            status,
	output logic [3:0]            slot,
	output logic [15:0]           fired_tag,
	output logic                  last
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PASS = 3'b010,
		ST_ACK  = 3'b100
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [SLOT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] add_slot_q;
	logic              took_q;
	logic              hit_q;

	logic              strobe_q;
	logic              rkind_q;
	logic [1:0]        status_q;
	logic [3:0]        slot_q;
	logic [15:0]       tag_q;
	logic              last_q;

	slot_t             ring [TIMER_SLOTS];
	slot_t             head_nxt;
	evt_t              evt;
	logic              shift;

	// the ring rotates one place per pass cycle; after a full pass every
	// slot sits back in its home cell
	assign shift = (state_q == ST_PASS);

	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
		if (i == TIMER_SLOTS - 1) begin : g_tail
			sttu_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
				.d(head_nxt), .q(ring[i]));
		end else begin : g_mid
			sttu_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
				.d(ring[i+1]), .q(ring[i]));
		end
	end

	// cell 0 holds slot cnt_q during pass cycle cnt_q
	sttu_proc u_proc (
		.cmd(cmd_q),
		.idx(cnt_q),
		.add_done(took_q),
		.cur(ring[0]),
		.nxt(head_nxt),
		.evt(evt)
	);

	assign busy = (state_q != ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			took_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PASS;
						cnt_q   <= '0;
						took_q  <= 1'b0;
						hit_q   <= 1'b0;
					end
				end
				ST_PASS: begin
					if (evt.took) took_q <= 1'b1;
					if (evt.hit)  hit_q  <= 1'b1;
					cnt_q <= cnt_q + SLOT_W'(1);
					if (cnt_q == SLOT_W'(TIMER_SLOTS - 1)) begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command latch and claimed slot (payload, no reset)
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= '{kind: kind, handle: handle, delay: DELAY_BITS'(delay_ticks),
				hdl: handler_valid, tag: handler_tag};
		end
		if (shift && evt.took) begin
			add_slot_q <= cnt_q;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (shift && evt.fire) || (state_q == ST_ACK);
		end
	end

	// result payload: fire during the pass, acknowledgement after it
	always_ff @(posedge clk) begin
		if (shift && evt.fire) begin
			rkind_q  <= RKIND_FIRE;
			status_q <= STATUS_OK;
			slot_q   <= 4'(cnt_q);
			tag_q    <= ring[0].tag;
			last_q   <= 1'b0;
		end else if (state_q == ST_ACK) begin
			rkind_q <= RKIND_ACK;
			tag_q   <= '0;
			last_q  <= 1'b1;
			case (cmd_q.kind)
				KIND_ADD: begin
					status_q <= took_q ? STATUS_OK : STATUS_FULL;
					slot_q   <= took_q ? 4'(add_slot_q) : 4'd0;
				end
				KIND_DELETE, KIND_MODIFY: begin
					status_q <= hit_q ? STATUS_OK : STATUS_NOT_LIVE;
					slot_q   <= cmd_q.handle;
				end
				default: begin
					status_q <= STATUS_OK;
					slot_q   <= 4'd0;
				end
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign result_kind   = rkind_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign fired_tag     = tag_q;
	assign last          = last_q;

	`STTU_ASSERT(a_start_goes_busy, (start && !busy) |=> busy, "start not taken")
	`STTU_ASSERT(a_ack_after_pass, (state_q == ST_ACK) |=> (result_strobe && last && result_kind == RKIND_ACK), "missing acknowledgement")
	`STTU_ASSERT(a_fire_in_pass, (result_strobe && !last) |-> ($past(state_q == ST_PASS) && result_kind == RKIND_FIRE && status == STATUS_OK), "fire outside a pass")
	`STTU_ASSERT_ALWAYS(a_idle_quiet, (!arst_n) |=> (!result_strobe || arst_n), "strobe during reset")
endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the software timer table unit.
`timescale 1ns / 100ps
module testbench;
	import sttu_pkg::*;

	// run shape
	localparam int ITEM_TARGET    = 130;  // stimulus stops once this many transfers went in
	localparam int CALM_ITEMS     = 20;   // closing stretch with no sender gaps
	localparam int WATCHDOG_LIMIT = 2000; // cycles with no transfer either way
	localparam int SETTLE_CYCLES  = 40;   // quiet tail after the last expected result is out
	localparam int REPORT_LIMIT   = 10;

	// one result as seen on the result ports
	typedef struct packed {
		logic        rkind;
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [15:0] tag;
		logic        last;
	} table_result_t;

	// directed row: command plus, where obvious, the acknowledgement typed in
	typedef struct {
		cmd_t       cmd;
		bit         typed;
		logic [1:0] status;
		logic [3:0] slot;
	} stim_row_t;

	// DUT ports; inputs known from time zero
	logic        clk;
	logic        arst_n        = 1'b0;
	logic        start         = 1'b0;
	logic        busy;
	logic [1:0]  kind          = KIND_TICK;
	logic [3:0]  handle        = '0;
	logic [31:0] delay_ticks   = '0;
	logic        handler_valid = 1'b0;
	logic [15:0] handler_tag   = '0;
	logic        result_strobe;
	logic        result_kind;
	logic [1:0]  status;
	logic [3:0]  slot;
	logic [15:0] fired_tag;
	logic        last;

	// typed acknowledgement travels with the command, updated at the same edge
	bit          ack_typed  = 1'b0;
	logic [1:0]  ack_status = STATUS_OK;
	logic [3:0]  ack_slot   = '0;

	// predictor's own copy of the timer table
	logic                  mirror_live  [TIMER_SLOTS];
	logic [DELAY_BITS-1:0] mirror_delay [TIMER_SLOTS];
	logic                  mirror_hdl   [TIMER_SLOTS];
	logic [TAG_W-1:0]      mirror_tag   [TIMER_SLOTS];

	table_result_t due_results[$];  // expected results, oldest first
	int            failures     = 0;
	int            issued       = 0;
	int            stall_cycles = 0;
	bit            idle_on      = 1'b1;

	software_timer_table_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.handle        (handle),
		.delay_ticks   (delay_ticks),
		.handler_valid (handler_valid),
		.handler_tag   (handler_tag),
		.result_strobe (result_strobe),
		.result_kind   (result_kind),
		.status        (status),
		.slot          (slot),
		.fired_tag     (fired_tag),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// table is empty after reset; other entries are only read once live
	initial foreach (mirror_live[i]) mirror_live[i] = 1'b0;

	function automatic table_result_t mk_result(logic rk, logic [1:0] st, logic [3:0] sl,
			logic [15:0] tg, logic lst);
		table_result_t r;
		r.rkind  = rk;
		r.status = st;
		r.slot   = sl;
		r.tag    = tg;
		r.last   = lst;
		return r;
	endfunction

	function automatic string fmt_result(table_result_t r);
		return $sformatf("kind=%0d status=%0d slot=%0d tag=%h last=%0d",
			r.rkind, r.status, r.slot, r.tag, r.last);
	endfunction

	// Apply one command to the mirror table and queue the results it causes.
	// Ticks fire in slot order; every command closes with one acknowledgement.
	function automatic void predict_table_results(input cmd_t c);
		bit claimed;
		claimed = 1'b0;
		case (c.kind)
			KIND_ADD: begin
				// lowest free slot wins
				for (int i = 0; i < TIMER_SLOTS; i++) begin
					if (!claimed && !mirror_live[i]) begin
						mirror_live[i]  = 1'b1;
						mirror_delay[i] = c.delay;
						mirror_hdl[i]   = c.hdl;
						mirror_tag[i]   = c.tag;
						due_results.push_back(mk_result(RKIND_ACK, STATUS_OK, 4'(i), '0, 1'b1));
						claimed = 1'b1;
					end
				end
				if (!claimed)
					due_results.push_back(mk_result(RKIND_ACK, STATUS_FULL, '0, '0, 1'b1));
			end
			KIND_DELETE, KIND_MODIFY: begin
				// a live slot parked at zero delay counts as not live
				if (int'(c.handle) < TIMER_SLOTS && mirror_live[c.handle] &&
						mirror_delay[c.handle] != '0) begin
					if (c.kind == KIND_DELETE)
						mirror_live[c.handle] = 1'b0;
					else
						mirror_delay[c.handle] = c.delay;
					due_results.push_back(mk_result(RKIND_ACK, STATUS_OK, c.handle, '0, 1'b1));
				end else begin
					due_results.push_back(
						mk_result(RKIND_ACK, STATUS_NOT_LIVE, c.handle, '0, 1'b1));
				end
			end
			KIND_TICK: begin
				// zero wraps to all ones; expiry without a handler is silent
				for (int i = 0; i < TIMER_SLOTS; i++) begin
					if (mirror_live[i]) begin
						mirror_delay[i] = mirror_delay[i] - 1'b1;
						if (mirror_delay[i] == '0) begin
							mirror_live[i] = 1'b0;
							if (mirror_hdl[i])
								due_results.push_back(
									mk_result(RKIND_FIRE, STATUS_OK, 4'(i), mirror_tag[i], 1'b0));
						end
					end
				end
				due_results.push_back(mk_result(RKIND_ACK, STATUS_OK, '0, '0, 1'b1));
			end
		endcase
	endfunction

	// Monitor: checks results, predicts on each start transfer, runs the watchdog.
	// Results are checked before the new command is predicted, so an
	// acknowledgement that overlaps the next start still matches its own command.
	always @(posedge clk) begin
		table_result_t got;
		table_result_t want;
		cmd_t          seen;
		bit            moved;
		if (arst_n) begin
			moved = 1'b0;
			if (result_strobe === 1'b1) begin
				moved = 1'b1;
				got = {result_kind, status, slot, fired_tag, last};
				if (due_results.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("%0t: unexpected result %s", $time, fmt_result(got));
				end else begin
					want = due_results.pop_front();
					if (got.rkind !== want.rkind || got.status !== want.status ||
							got.slot !== want.slot || got.tag !== want.tag ||
							got.last !== want.last) begin
						failures++;
						if (failures <= REPORT_LIMIT)
							$display("%0t: result mismatch, expected %s, got %s", $time,
								fmt_result(want), fmt_result(got));
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				moved = 1'b1;
				seen.kind   = kind;
				seen.handle = handle;
				seen.delay  = delay_ticks;
				seen.hdl    = handler_valid;
				seen.tag    = handler_tag;
				predict_table_results(seen);
				// typed rows: mirror still advances, the hand-written ack is the reference
				if (ack_typed) begin
					void'(due_results.pop_back());
					due_results.push_back(mk_result(RKIND_ACK, ack_status, ack_slot, '0, 1'b1));
				end
			end
			if (moved) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: watchdog, no transfer for %0d cycles", $time, stall_cycles);
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	// Present a command and hold it until the start transfer.
	task automatic issue(input cmd_t c, input bit typed, input logic [1:0] st,
			input logic [3:0] sl);
		start         <= 1'b1;
		kind          <= c.kind;
		handle        <= c.handle;
		delay_ticks   <= c.delay;
		handler_valid <= c.hdl;
		handler_tag   <= c.tag;
		ack_typed     <= typed;
		ack_status    <= st;
		ack_slot      <= sl;
		do @(posedge clk); while (busy !== 1'b0);
		issued++;
	endtask

	// Sender gaps in bursts, switched on and off in stretches; none near the end.
	task automatic maybe_idle();
		if (issued >= ITEM_TARGET - CALM_ITEMS)
			return;
		if ($urandom_range(0, 11) == 0)
			idle_on = !idle_on;
		if (idle_on && $urandom_range(0, 1) == 1) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Hold off until every expected result is out.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	task automatic send(input cmd_t c);
		maybe_idle();
		issue(c, 1'b0, STATUS_OK, '0);
	endtask

	function automatic cmd_t random_cmd();
		cmd_t c;
		int   open_slots[$];
		int   pick;
		c.handle = 4'($urandom);
		c.hdl    = ($urandom_range(0, 4) != 0);
		c.tag    = TAG_W'($urandom);
		// mostly short delays so slots expire; zero, full-width and max are rare
		// since they park a slot for good
		pick = $urandom_range(0, 19);
		if (pick == 0)
			c.delay = '0;
		else if (pick == 1)
			c.delay = DELAY_BITS'($urandom);
		else if (pick == 2)
			c.delay = '1;
		else if (pick < 16)
			c.delay = DELAY_BITS'($urandom_range(1, 4));
		else
			c.delay = DELAY_BITS'($urandom_range(5, 30));
		pick = $urandom_range(0, 99);
		if (pick < 35)
			c.kind = KIND_TICK;
		else if (pick < 65)
			c.kind = KIND_ADD;
		else if (pick < 82)
			c.kind = KIND_DELETE;
		else
			c.kind = KIND_MODIFY;
		// aim delete/modify at a live slot most of the time
		if ((c.kind == KIND_DELETE || c.kind == KIND_MODIFY) && $urandom_range(0, 3) != 0) begin
			foreach (mirror_live[i])
				if (mirror_live[i] && mirror_delay[i] != '0)
					open_slots.push_back(i);
			if (open_slots.size() != 0)
				c.handle = 4'(open_slots[$urandom_range(0, open_slots.size() - 1)]);
		end
		return c;
	endfunction

	// Fill every free slot with a one-tick timer (overflowing a non-empty table),
	// then tick: on an empty table this gives the longest burst of fires.
	task automatic flood_and_expire();
		cmd_t c;
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			c       = random_cmd();
			c.kind  = KIND_ADD;
			c.delay = DELAY_BITS'(1);
			c.hdl   = ($urandom_range(0, 7) != 0);
			send(c);
		end
		c      = random_cmd();
		c.kind = KIND_TICK;
		send(c);
	endtask

	function automatic stim_row_t row(logic [1:0] k, logic [3:0] h, logic [31:0] d, logic v,
			logic [15:0] t, bit typed, logic [1:0] st, logic [3:0] sl);
		stim_row_t r;
		r.cmd.kind   = k;
		r.cmd.handle = h;
		r.cmd.delay  = d;
		r.cmd.hdl    = v;
		r.cmd.tag    = t;
		r.typed      = typed;
		r.status     = st;
		r.slot       = sl;
		return r;
	endfunction

	initial begin
		stim_row_t rows[$];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, fill to full, the not-live corners, wrap and expiry
		rows.push_back(row(KIND_DELETE, 4'd0, 32'd0, 1'b0, 16'h0000, 1, STATUS_NOT_LIVE, 4'd0));
		rows.push_back(row(KIND_TICK, 4'd0, 32'd0, 1'b0, 16'h0000, 1, STATUS_OK, 4'd0));
		rows.push_back(row(KIND_ADD, 4'd0, 32'd1, 1'b1, 16'hFFFF, 1, STATUS_OK, 4'd0));
		// zero delay: accepted, wraps on the next tick
		rows.push_back(row(KIND_ADD, 4'd0, 32'd0, 1'b1, 16'h0000, 1, STATUS_OK, 4'd1));
		rows.push_back(row(KIND_ADD, 4'd0, 32'hFFFF_FFFF, 1'b0, 16'h1234, 1, STATUS_OK, 4'd2));
		// expires silently, no handler
		rows.push_back(row(KIND_ADD, 4'd0, 32'd1, 1'b0, 16'hABCD, 1, STATUS_OK, 4'd3));
		for (int k = 4; k < 15; k++)
			rows.push_back(row(KIND_ADD, 4'd0, (k % 3 == 0) ? 32'd2 : 32'd1, 1'b1,
				16'hA500 | 16'(k), 1, STATUS_OK, 4'(k)));
		rows.push_back(row(KIND_ADD, 4'd0, 32'h8000_0000, 1'b1, 16'h00FF, 1, STATUS_OK, 4'd15));
		// table full
		rows.push_back(row(KIND_ADD, 4'd0, 32'd7, 1'b1, 16'h7777, 1, STATUS_FULL, 4'd0));
		// live but parked at zero: not live
		rows.push_back(row(KIND_DELETE, 4'd1, 32'd0, 1'b0, 16'h0000, 1, STATUS_NOT_LIVE, 4'd1));
		rows.push_back(row(KIND_MODIFY, 4'd15, 32'd1, 1'b0, 16'h0000, 1, STATUS_OK, 4'd15));
		rows.push_back(row(KIND_TICK, 4'd0, 32'd0, 1'b0, 16'h0000, 0, STATUS_OK, 4'd0));
		rows.push_back(row(KIND_DELETE, 4'd2, 32'd0, 1'b0, 16'h0000, 1, STATUS_OK, 4'd2));
		// slot 1 wrapped to all ones, so it is live again
		rows.push_back(row(KIND_MODIFY, 4'd1, 32'd1, 1'b0, 16'h0000, 1, STATUS_OK, 4'd1));
		rows.push_back(row(KIND_TICK, 4'd0, 32'd0, 1'b0, 16'h0000, 0, STATUS_OK, 4'd0));

		foreach (rows[i]) begin
			maybe_idle();
			issue(rows[i].cmd, rows[i].typed, rows[i].status, rows[i].slot);
		end

		// table is empty again: the flood's tick fires every slot that has a handler
		drain();
		flood_and_expire();

		while (issued < ITEM_TARGET) begin
			if ($urandom_range(0, 39) == 0)
				flood_and_expire();
			else
				send(random_cmd());
			if ($urandom_range(0, 24) == 0)
				drain();
		end
		start <= 1'b0;

		do @(posedge clk); while (due_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		failures += due_results.size();
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
